@@ sv/psfp_pkg.sv @@
package psfp_pkg;

  // Frame layout of the sensor's serial protocol.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValW     = 16;
  localparam int unsigned IdxW     = 5;

  localparam logic [ByteW-1:0] HdrFirst  = 8'h42;
  localparam logic [ByteW-1:0] HdrSecond = 8'h4d;

  // Byte positions within the 24-byte frame.
  localparam logic [IdxW-1:0] IdxBodyStart = 5'd2;
  localparam logic [IdxW-1:0] IdxSumLast   = 5'd21;
  localparam logic [IdxW-1:0] IdxPm1Hi     = 5'd10;
  localparam logic [IdxW-1:0] IdxPm1Lo     = 5'd11;
  localparam logic [IdxW-1:0] IdxPm25Hi    = 5'd12;
  localparam logic [IdxW-1:0] IdxPm25Lo    = 5'd13;
  localparam logic [IdxW-1:0] IdxPm10Hi    = 5'd14;
  localparam logic [IdxW-1:0] IdxPm10Lo    = 5'd15;
  localparam logic [IdxW-1:0] IdxChkHi     = 5'd22;
  localparam logic [IdxW-1:0] IdxChkLo     = 5'd23;
  localparam logic [IdxW-1:0] FrameLen     = 5'd24;

  // Sum of the two header bytes, the starting point of the checksum.
  localparam logic [ValW-1:0] HdrSum = ValW'(HdrFirst) + ValW'(HdrSecond);

  // One result transaction as produced by the parser.
  typedef struct packed {
    logic            frame_ok;
    logic [ValW-1:0] pm1;
    logic [ValW-1:0] pm25;
    logic [ValW-1:0] pm10;
  } psfp_result_t;

endpackage

@@ sv/psfp_core.sv @@
module psfp_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic [psfp_pkg::ByteW-1:0]        rx_byte_i,
  output logic                              res_valid_o,
  output psfp_pkg::psfp_result_t            res_o
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SECOND  = 2'd1,
    PH_COLLECT = 2'd2
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [psfp_pkg::IdxW-1:0]       idx_q, idx_d;
  logic [psfp_pkg::ValW-1:0]       sum_q, sum_d;
  logic [psfp_pkg::ValW-1:0]       pm1_q, pm1_d;
  logic [psfp_pkg::ValW-1:0]       pm25_q, pm25_d;
  logic [psfp_pkg::ValW-1:0]       pm10_q, pm10_d;
  logic [psfp_pkg::ByteW-1:0]      chk_hi_q, chk_hi_d;
  logic [psfp_pkg::ValW-1:0]       held_pm1_q, held_pm1_d;
  logic [psfp_pkg::ValW-1:0]       held_pm25_q, held_pm25_d;
  logic [psfp_pkg::ValW-1:0]       held_pm10_q, held_pm10_d;
  logic                            done;
  logic                            sum_match;

  assign sum_match = ({chk_hi_q, rx_byte_i} == sum_q);

  // Next-state logic for one received byte.
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    pm1_d       = pm1_q;
    pm25_d      = pm25_q;
    pm10_d      = pm10_q;
    chk_hi_d    = chk_hi_q;
    held_pm1_d  = held_pm1_q;
    held_pm25_d = held_pm25_q;
    held_pm10_d = held_pm10_q;
    done        = 1'b0;

    case (phase_q)
      PH_SECOND: begin
        // A wrong second byte is dropped and the hunt starts over.
        if (rx_byte_i == psfp_pkg::HdrSecond) begin
          phase_d = PH_COLLECT;
          idx_d   = psfp_pkg::IdxBodyStart;
          sum_d   = psfp_pkg::HdrSum;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_COLLECT: begin
        if (idx_q < psfp_pkg::IdxBodyStart || idx_q >= psfp_pkg::FrameLen) begin
          phase_d = PH_HUNT;
          idx_d   = '0;
        end else begin
          if (idx_q <= psfp_pkg::IdxSumLast) begin
            sum_d = sum_q + psfp_pkg::ValW'(rx_byte_i);
          end
          case (idx_q)
            psfp_pkg::IdxPm1Hi:  pm1_d    = {rx_byte_i, 8'h00};
            psfp_pkg::IdxPm1Lo:  pm1_d    = {pm1_q[15:8], rx_byte_i};
            psfp_pkg::IdxPm25Hi: pm25_d   = {rx_byte_i, 8'h00};
            psfp_pkg::IdxPm25Lo: pm25_d   = {pm25_q[15:8], rx_byte_i};
            psfp_pkg::IdxPm10Hi: pm10_d   = {rx_byte_i, 8'h00};
            psfp_pkg::IdxPm10Lo: pm10_d   = {pm10_q[15:8], rx_byte_i};
            psfp_pkg::IdxChkHi:  chk_hi_d = rx_byte_i;
            default: ;
          endcase
          if (idx_q == psfp_pkg::IdxChkLo) begin
            // Last byte: check the frame and latch the values if it is good.
            done    = 1'b1;
            phase_d = PH_HUNT;
            idx_d   = '0;
            if (sum_match) begin
              held_pm1_d  = pm1_q;
              held_pm25_d = pm25_q;
              held_pm10_d = pm10_q;
            end
          end else begin
            idx_d = idx_q + psfp_pkg::IdxW'(1);
          end
        end
      end
      default: begin
        phase_d = (rx_byte_i == psfp_pkg::HdrFirst) ? PH_SECOND : PH_HUNT;
      end
    endcase
  end

  // Parser state advances only when a byte is stepped through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      idx_q       <= '0;
      sum_q       <= '0;
      pm1_q       <= '0;
      pm25_q      <= '0;
      pm10_q      <= '0;
      chk_hi_q    <= '0;
      held_pm1_q  <= '0;
      held_pm25_q <= '0;
      held_pm10_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      pm1_q       <= pm1_d;
      pm25_q      <= pm25_d;
      pm10_q      <= pm10_d;
      chk_hi_q    <= chk_hi_d;
      held_pm1_q  <= held_pm1_d;
      held_pm25_q <= held_pm25_d;
      held_pm10_q <= held_pm10_d;
    end
  end

  assign res_valid_o   = step_i && done;
  assign res_o.frame_ok = sum_match;
  assign res_o.pm1      = held_pm1_d;
  assign res_o.pm25     = held_pm25_d;
  assign res_o.pm10     = held_pm10_d;

endmodule

@@ sv/particulate_sensor_frame_parser.sv @@
// A byte accepted into the input register is parsed when it moves on from there;
// a finished frame's result enters the output register as that byte is parsed.
// Throughput: one byte per cycle; one more byte is held while a result is
// blocked, after which the input stalls until that result is taken.
// Reset: asynchronous, active low; parser returns to header hunt, held values
// and all valid flags clear.
module particulate_sensor_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [psfp_pkg::ByteW-1:0]    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          frame_ok_o,
  output logic [psfp_pkg::ValW-1:0]     pm1_value_o,
  output logic [psfp_pkg::ValW-1:0]     pm25_value_o,
  output logic [psfp_pkg::ValW-1:0]     pm10_value_o
);

  logic                          in_vld_q;
  logic [psfp_pkg::ByteW-1:0]    in_byte_q;
  logic                          in_accept;
  logic                          proc_go;
  logic                          res_valid;
  psfp_pkg::psfp_result_t        res;
  logic                          out_vld_q;
  psfp_pkg::psfp_result_t        out_q;

  // The held byte moves on unless a finished result is still blocked.
  assign proc_go    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !proc_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (proc_go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  psfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (proc_go),
    .rx_byte_i   (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register; a new result replaces one that is being taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign frame_ok_o   = out_q.frame_ok;
  assign pm1_value_o  = out_q.pm1;
  assign pm25_value_o = out_q.pm25;
  assign pm10_value_o = out_q.pm10;

`ifndef SYNTHESIS
  // The input side only stalls while a byte is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with empty input register");

  // A result is only produced when the output register is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (proc_go && (!out_vld_q || !out_stall_i)))
    else $error("result produced over a blocked transaction");

  // A result that is produced shows up in the output register next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> (out_valid_o && out_q == $past(res)))
    else $error("produced result not registered");

  // A taken result with nothing new behind it leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !res_valid) |=> !out_valid_o)
    else $error("result repeated after it was taken");
`endif

endmodule
